// ----- rtl/rrsa_pkg.sv -----
`default_nettype none

package rrsa_pkg;

   // sizing
   localparam int SERVERS    = 8;
   localparam int SLOTS      = 4;
   localparam int SRV_W      = 3;   // server index
   localparam int SRV_CNT_W  = 4;   // server count, holds SERVERS itself
   localparam int SLOT_W     = 2;   // slot index
   localparam int SLOT_CNT_W = 3;   // per-server slot count field
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int UPC_W      = 3;

   // operation codes
   localparam logic [OP_W-1:0] OP_ASSIGN  = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_FAIL    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SERVER_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNTS  = 2'd1;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [SRV_W-1:0]  server_sel;
      logic [SLOT_W-1:0] slot_sel;
   } req_word_type;

   typedef struct packed {
      logic              granted;
      logic [SRV_W-1:0]  server_out;
      logic [SLOT_W-1:0] slot_out;
   } rsp_word_type;

   // microprogram addresses
   typedef logic [UPC_W-1:0] upc_type;
   localparam upc_type UPC_FETCH = 3'd0;
   localparam upc_type UPC_START = 3'd1;
   localparam upc_type UPC_SCAN  = 3'd2;
   localparam upc_type UPC_GRANT = 3'd3;
   localparam upc_type UPC_FREE  = 3'd4;
   localparam upc_type UPC_EMIT  = 3'd5;

   typedef enum logic [2:0] {
      BR_ALWAYS,
      BR_DISPATCH,
      BR_EMPTY,
      BR_SCAN,
      BR_EMIT
   } br_type;

   typedef struct packed {
      logic    wait_req;
      logic    load_scan;
      logic    scan;
      logic    grant;
      logic    release_slot;
      logic    emit;
      br_type  br;
      upc_type target;
   } ctl_type;

   // microprogram rom
   function automatic ctl_type ucode_rom(upc_type addr);
      ctl_type c;
      c = '{wait_req: 1'b0, load_scan: 1'b0, scan: 1'b0, grant: 1'b0,
            release_slot: 1'b0, emit: 1'b0, br: BR_ALWAYS, target: UPC_FETCH};
      case (addr)
         UPC_FETCH: begin
            c.wait_req = 1'b1;
            c.br       = BR_DISPATCH;
            c.target   = UPC_START;
         end
         UPC_START: begin
            c.load_scan = 1'b1;
            c.br        = BR_EMPTY;
            c.target    = UPC_SCAN;
         end
         UPC_SCAN: begin
            c.scan   = 1'b1;
            c.br     = BR_SCAN;
            c.target = UPC_GRANT;
         end
         UPC_GRANT: begin
            c.grant  = 1'b1;
            c.target = UPC_EMIT;
         end
         UPC_FREE: begin
            c.release_slot = 1'b1;
            c.target       = UPC_EMIT;
         end
         UPC_EMIT: begin
            c.emit   = 1'b1;
            c.br     = BR_EMIT;
            c.target = UPC_FETCH;
         end
         default: begin
            c.target = UPC_FETCH;
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/round_robin_slot_allocator_unit.sv -----
`default_nettype none

// channel   direction  handshake            word
// req       in         req_valid/req_stall  rrsa_pkg::req_word_type
// rsp       out        rsp_valid/rsp_stall  rrsa_pkg::rsp_word_type
// csr       in         csr_valid/csr_ready  csr_index, csr_data
//
// a release or failure report goes through the free and emit steps, an unused
// op code straight to emit, and an assign through start, then scan, grant and
// emit, or to emit without a grant when the scan visits every live server or
// no servers are in rotation; the scan step tests one server per cycle
// the sequencer is back in fetch at the edge that raises rsp_valid, and a new
// request word is taken only in fetch, never while one is still in progress
// reset clears the busy map, restores all servers active, zeroes the pointer
// and the registers; no clearing pass
// rsp is an output register: the next word is taken while a result waits,
// the sequencer only holds in its emit step while that register is full and stalled

module round_robin_slot_allocator_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire rrsa_pkg::req_word_type           req_word,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output rrsa_pkg::rsp_word_type                rsp_word,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire [rrsa_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire [rrsa_pkg::CSR_DATA_W-1:0]        csr_data
);
   import rrsa_pkg::*;

   // sequencer
   upc_type upc_ff, upc_in;
   ctl_type ctl;

   // datapath registers
   req_word_type      cmd_ff, cmd_in;       // latched request word
   logic [SRV_W-1:0]  cur_ff, cur_in;       // server under scan
   logic [SRV_W-1:0]  cnt_ff, cnt_in;       // servers visited minus one
   logic [SLOT_W-1:0] pick_ff, pick_in;     // free slot of cur_ff
   rsp_word_type      res_ff, res_in;       // result being built
   rsp_word_type      rsp_ff, rsp_in;       // output register
   logic              rsp_valid_ff, rsp_valid_in;

   // allocator state
   logic [SLOTS-1:0]      busy_ff [SERVERS];
   logic [SLOTS-1:0]      busy_in [SERVERS];
   logic [SERVERS-1:0]    active_ff, active_in;
   logic [SRV_W-1:0]      ptr_ff, ptr_in;
   logic [SRV_CNT_W-1:0]  server_count_ff, server_count_in;
   logic [CSR_DATA_W-1:0] slot_counts_ff, slot_counts_in;

   // combinational helpers
   logic                  req_acc;
   logic                  out_free;
   logic [SRV_CNT_W-1:0]  nlive;
   logic [SRV_W-1:0]      last_srv;
   logic [SRV_W-1:0]      nxt;
   logic [SLOT_CNT_W-1:0] nxt_raw;
   logic [SLOT_CNT_W-1:0] nxt_cnt;
   logic                  nxt_free;
   logic [SLOT_W-1:0]     nxt_slot;
   logic                  hit;
   logic                  cfg_hit;

   assign ctl       = ucode_rom(upc_ff);
   assign req_stall = ~ctl.wait_req;
   assign req_acc   = req_valid & ctl.wait_req;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   // live servers, saturated at SERVERS
   assign nlive    = (server_count_ff > SRV_CNT_W'(SERVERS)) ? SRV_CNT_W'(SERVERS)
                                                             : server_count_ff;
   assign last_srv = SRV_W'(nlive - SRV_CNT_W'(1));

   // next server in rotation, wraps after the last live one
   assign nxt = (cur_ff == last_srv) ? '0 : cur_ff + SRV_W'(1);

   // slot count of the next server, saturated at SLOTS
   assign nxt_raw = slot_counts_ff[SLOT_CNT_W*nxt +: SLOT_CNT_W];
   assign nxt_cnt = (nxt_raw > SLOT_CNT_W'(SLOTS)) ? SLOT_CNT_W'(SLOTS) : nxt_raw;

   // lowest free slot below the count
   always_comb begin
      nxt_free = 1'b0;
      nxt_slot = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if ((SLOT_CNT_W'(i) < nxt_cnt) && !busy_ff[nxt][i]) begin
            nxt_free = 1'b1;
            nxt_slot = SLOT_W'(i);
         end
      end
   end

   assign hit = active_ff[nxt] & nxt_free;

   // next microprogram address
   always_comb begin
      upc_in = upc_ff;
      case (ctl.br)
         BR_ALWAYS: begin
            upc_in = ctl.target;
         end
         BR_DISPATCH: begin
            if (req_acc) begin
               case (req_word.operation)
                  OP_ASSIGN:  upc_in = ctl.target;
                  OP_RELEASE: upc_in = UPC_FREE;
                  OP_FAIL:    upc_in = UPC_FREE;
                  default:    upc_in = UPC_EMIT;
               endcase
            end
         end
         BR_EMPTY: begin
            // no servers in rotation: straight to a no-grant result
            upc_in = (nlive == '0) ? UPC_EMIT : ctl.target;
         end
         BR_SCAN: begin
            if (hit) begin
               upc_in = ctl.target;
            end else if (cnt_ff == last_srv) begin
               upc_in = UPC_EMIT;
            end else begin
               upc_in = UPC_SCAN;
            end
         end
         BR_EMIT: begin
            upc_in = out_free ? ctl.target : UPC_EMIT;
         end
         default: begin
            upc_in = UPC_FETCH;
         end
      endcase
   end

   // datapath driven by the control word
   always_comb begin
      cmd_in          = cmd_ff;
      cur_in          = cur_ff;
      cnt_in          = cnt_ff;
      pick_in         = pick_ff;
      res_in          = res_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff;
      busy_in         = busy_ff;
      active_in       = active_ff;
      ptr_in          = ptr_ff;
      server_count_in = server_count_ff;
      slot_counts_in  = slot_counts_ff;
      cfg_hit         = 1'b0;

      // fresh request: latch it, start from an all-zero result
      if (req_acc) begin
         cmd_in = req_word;
         res_in = '0;
      end

      // scan setup: start after the last pick
      if (ctl.load_scan) begin
         cur_in = ptr_ff;
         cnt_in = '0;
      end

      // one server per step
      if (ctl.scan) begin
         cur_in  = nxt;
         cnt_in  = cnt_ff + SRV_W'(1);
         pick_in = nxt_slot;
      end

      if (ctl.grant) begin
         busy_in[cur_ff][pick_ff] = 1'b1;
         ptr_in = cur_ff;
         res_in = '{granted: 1'b1, server_out: cur_ff, slot_out: pick_ff};
      end

      if (ctl.release_slot) begin
         busy_in[cmd_ff.server_sel][cmd_ff.slot_sel] = 1'b0;
         if (cmd_ff.operation == OP_FAIL) begin
            active_in[cmd_ff.server_sel] = 1'b0;
         end
      end

      // output register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.emit && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_ff;
      end

      // writes to either known register index reload the active flags and the pointer
      if (csr_valid) begin
         case (csr_index)
            CSR_SERVER_COUNT: begin
               server_count_in = csr_data[SRV_CNT_W-1:0];
               cfg_hit         = 1'b1;
            end
            CSR_SLOT_COUNTS: begin
               slot_counts_in = csr_data;
               cfg_hit        = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
      if (cfg_hit) begin
         active_in = '1;
         ptr_in    = '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff          <= UPC_FETCH;
         rsp_valid_ff    <= 1'b0;
         active_ff       <= '1;
         ptr_ff          <= '0;
         server_count_ff <= '0;
         slot_counts_ff  <= '0;
         for (int s = 0; s < SERVERS; s++) begin
            busy_ff[s] <= '0;
         end
      end else begin
         upc_ff          <= upc_in;
         rsp_valid_ff    <= rsp_valid_in;
         active_ff       <= active_in;
         ptr_ff          <= ptr_in;
         server_count_ff <= server_count_in;
         slot_counts_ff  <= slot_counts_in;
         busy_ff         <= busy_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      cur_ff  <= cur_in;
      cnt_ff  <= cnt_in;
      pick_ff <= pick_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   // a result only appears from the emit step
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(upc_ff) == UPC_EMIT)
      else $error("result raised outside emit step");

   // an accepted request always leaves the fetch step
   a_fetch_leaves: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> upc_ff != UPC_FETCH)
      else $error("sequencer stayed in fetch after accept");

   // a grant marks its slot busy
   a_grant_marks: assert property (@(posedge clock) disable iff (reset)
      ctl.grant |=> busy_ff[$past(cur_ff)][$past(pick_ff)])
      else $error("granted slot not marked busy");

endmodule

`default_nettype wire
